[rtl/dsg_pkg.sv]
// dsg_pkg: shared types and constants of the decaying sine generator
// controller command and status structs, state codes, register indexes
// no dependencies
package dsg_pkg;

  // default build parameters
  localparam int DefaultSineTableDepth = 1024;
  localparam int DefaultCountBits      = 24;

  // fixed field widths of the interface
  localparam int PhaseW   = 32;
  localparam int AmpW     = 15;
  localparam int DecayW   = 32;
  localparam int FrameW   = 24;
  localparam int WordW    = 32;
  localparam int MagW     = 15;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PHASE_STEP   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_AMPLITUDE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DECAY_FACTOR = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_COUNT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FLOAT_FORMAT = 3'd4;

  // register reset values
  localparam logic [PhaseW-1:0] PHASE_STEP_RST   = '0;
  localparam logic [AmpW-1:0]   AMPLITUDE_RST    = 15'h7FFF;
  localparam logic [DecayW-1:0] DECAY_FACTOR_RST = 32'hFFFF_FFFF;
  localparam logic [FrameW-1:0] SAMPLE_COUNT_RST = '0;

  // envelope start value, nearly unity in Q0.32
  localparam logic [31:0] ENVELOPE_START = 32'hFFFF_FFFF;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ROM  = 5'b00010,
    ST_AMP  = 5'b00100,
    ST_ENV  = 5'b01000,
    ST_FIN  = 5'b10000
  } dsg_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic start;     // transaction accepted, latch run context
    logic rom_read;  // read sine table
    logic mul_amp;   // sine magnitude times amplitude
    logic mul_env;   // partial product times envelope
    logic finish;    // commit state and load output register
  } dsg_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } dsg_status_t;

endpackage

[rtl/dsg_ctrl.sv]
// dsg_ctrl: sequencing state machine for one sample per transaction
// depends on dsg_pkg for state codes and the command/status structs
module dsg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dsg_pkg::dsg_status_t st,
  output dsg_pkg::dsg_cmd_t    cmd
);
  import dsg_pkg::*;

  dsg_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_ROM;
        end
      end
      ST_ROM: begin
        cmd.rom_read = 1'b1;
        state_next   = ST_AMP;
      end
      ST_AMP: begin
        cmd.mul_amp = 1'b1;
        state_next  = ST_ENV;
      end
      ST_ENV: begin
        cmd.mul_env = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        // hold until the previous result has left the output register
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // no transaction is taken while in reset
  assign in_stall = rst || (state != ST_IDLE);

endmodule

[rtl/dsg_datapath.sv]
// dsg_datapath: run state, sine rom, shared multiplier, output register
// depends on dsg_pkg; driven by dsg_ctrl commands
module dsg_datapath #(
  parameter int SINE_TABLE_DEPTH = dsg_pkg::DefaultSineTableDepth,
  parameter int COUNT_BITS       = dsg_pkg::DefaultCountBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dsg_pkg::dsg_cmd_t             cmd,
  output dsg_pkg::dsg_status_t          st,
  input  logic                          restart,
  input  logic [dsg_pkg::PhaseW-1:0]    phase_step,
  input  logic [dsg_pkg::AmpW-1:0]      amplitude,
  input  logic [dsg_pkg::DecayW-1:0]    decay_factor,
  input  logic [dsg_pkg::FrameW-1:0]    sample_count,
  input  logic                          float_format,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsg_pkg::WordW-1:0]     sample_word,
  output logic                          sample_valid,
  output logic [dsg_pkg::FrameW-1:0]    frame_index,
  output logic                          last_sample,
  output logic [dsg_pkg::MagW-1:0]      peak_magnitude,
  output logic [dsg_pkg::FrameW-1:0]    peak_frame
);
  import dsg_pkg::*;

  localparam int IdxW   = $clog2(SINE_TABLE_DEPTH);
  localparam int DepthW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IprodW = PhaseW + DepthW;

  // quarter-wave polynomial coefficients, Q30
  localparam logic [63:0] PC1 = 64'd1686629713;
  localparam logic [63:0] PC3 = 64'd693598668;
  localparam logic [63:0] PC5 = 64'd85569306;
  localparam logic [63:0] PC7 = 64'd5026995;
  localparam logic [63:0] PC9 = 64'd172272;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // one table entry from its quadrant and Q30 position in the quadrant
  function automatic logic [15:0] sine_entry(input logic [1:0] quad, input logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = quad[0] ? (Q30_ONE - xin) : xin;
    x2 = (x * x) >> 30;
    t  = PC9;
    t  = PC7 - ((x2 * t) >> 30);
    t  = PC5 - ((x2 * t) >> 30);
    t  = PC3 - ((x2 * t) >> 30);
    t  = PC1 - ((x2 * t) >> 30);
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return quad[1] ? (16'd0 - v[15:0]) : v[15:0];
  endfunction

  // sine rom, constant contents built at elaboration
  logic [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] P    = 64'(k) * 64'd4;
    localparam logic [63:0] QUAD = P / SINE_TABLE_DEPTH;
    localparam logic [63:0] XPOS = ((P % SINE_TABLE_DEPTH) << 30) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = sine_entry(QUAD[1:0], XPOS);
  end

  // run state
  logic [PhaseW-1:0]     phase_acc;
  logic [31:0]           envelope;
  logic [COUNT_BITS-1:0] frame_counter;
  logic [MagW-1:0]       peak_value;
  logic [COUNT_BITS-1:0] peak_index;

  // per-transaction context
  logic [IdxW-1:0]       idx_q;
  logic                  active_q;
  logic                  last_q;
  logic [15:0]           rom_q;
  logic [63:0]           prod_q;

  // effective values after an optional restart
  logic [PhaseW-1:0]     phase_eff;
  logic [COUNT_BITS-1:0] frame_eff;
  logic [COUNT_BITS-1:0] count;
  logic [IprodW-1:0]     idx_prod;

  assign phase_eff = restart ? '0 : phase_acc;
  assign frame_eff = restart ? '0 : frame_counter;
  assign count     = COUNT_BITS'(sample_count);
  assign idx_prod  = {{DepthW{1'b0}}, phase_eff} * IprodW'(SINE_TABLE_DEPTH);

  // sine magnitude and sign
  logic            neg;
  logic [15:0]     neg_rom;
  logic [MagW-1:0] sine_mag;

  assign neg      = rom_q[15];
  assign neg_rom  = 16'd0 - rom_q;
  assign sine_mag = neg ? neg_rom[MagW-1:0] : rom_q[MagW-1:0];

  // shared 32x32 multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    if (cmd.mul_amp) begin
      mul_a = 32'(sine_mag);
      mul_b = 32'(amplitude);
    end else if (cmd.mul_env) begin
      mul_a = envelope;
      mul_b = 32'(prod_q[29:0]);
    end else begin
      mul_a = envelope;
      mul_b = decay_factor;
    end
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // sample magnitude, Q0.15
  logic [MagW-1:0] mag;
  assign mag = prod_q[61:47];

  // leading one of the magnitude
  logic [3:0] lead;
  always_comb begin
    lead = '0;
    for (int i = 0; i < MagW; i++) begin
      if (mag[i]) begin
        lead = 4'(i);
      end
    end
  end

  // int16 and IEEE single encodings
  logic [15:0]       int_word;
  logic [23:0]       mant_shift;
  logic [7:0]        exp_field;
  logic [WordW-1:0]  flt_word;
  logic [WordW-1:0]  word_next;

  assign int_word   = neg ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
  assign mant_shift = 24'(mag) << (5'd23 - 5'(lead));
  assign exp_field  = 8'(lead) + 8'd112;
  assign flt_word   = (mag == '0) ? '0 : {neg, exp_field, mant_shift[22:0]};

  always_comb begin
    if (!active_q) begin
      word_next = '0;
    end else if (float_format) begin
      word_next = flt_word;
    end else begin
      word_next = {16'd0, int_word};
    end
  end

  // peak tracking
  logic                  peak_upd;
  logic [MagW-1:0]       peak_value_next;
  logic [COUNT_BITS-1:0] peak_index_next;

  assign peak_upd        = active_q && (mag > peak_value);
  assign peak_value_next = peak_upd ? mag : peak_value;
  assign peak_index_next = peak_upd ? frame_counter : peak_index;

  // run state updates: clear on restart, advance on commit of an active sample
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc     <= '0;
      envelope      <= ENVELOPE_START;
      frame_counter <= '0;
      peak_value    <= '0;
      peak_index    <= '0;
    end else if (cmd.start && restart) begin
      phase_acc     <= '0;
      envelope      <= ENVELOPE_START;
      frame_counter <= '0;
      peak_value    <= '0;
      peak_index    <= '0;
    end else if (cmd.finish && active_q) begin
      phase_acc     <= phase_acc + phase_step;
      envelope      <= mul_p[63:32];
      frame_counter <= frame_counter + COUNT_BITS'(1);
      peak_value    <= peak_value_next;
      peak_index    <= peak_index_next;
    end
  end

  // transaction context and product pipeline
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_q    <= idx_prod[PhaseW +: IdxW];
      active_q <= frame_eff < count;
      last_q   <= frame_eff == (count - COUNT_BITS'(1));
    end
    if (cmd.rom_read) begin
      rom_q <= sine_rom[idx_q];
    end
    if (cmd.mul_amp || cmd.mul_env) begin
      prod_q <= mul_p;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample_word    <= word_next;
      sample_valid   <= active_q;
      frame_index    <= FrameW'(frame_counter);
      last_sample    <= active_q && last_q;
      peak_magnitude <= peak_value_next;
      peak_frame     <= FrameW'(peak_index_next);
    end
  end

  assign st.out_free = !out_valid || !out_stall;

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken transaction");

  // a committed result is presented on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("committed result not presented");

  // a stopped tone gives a zero word and no last flag
  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !sample_valid) |-> (sample_word == '0 && !last_sample))
    else $error("stopped tone gave a nonzero sample");

  // peak only falls through a restart
  a_peak_mono: assert property (@(posedge clk) disable iff (rst)
    !(cmd.start && restart) |=> peak_value >= $past(peak_value))
    else $error("peak magnitude decreased without restart");

endmodule

[rtl/decaying_sine_generator.sv]
// decaying_sine_generator: top level, configuration registers and hookup
// depends on dsg_pkg, dsg_ctrl and dsg_datapath
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   in       | in_valid/in_stall  | restart
//   out      | out_valid/out_stall| sample_word, sample_valid, frame_index,
//            |                    | last_sample, peak_magnitude, peak_frame
//   cfg      | cfg_write          | cfg_index, cfg_data
//
// a tick is accepted in idle, then its result is built by the rom read, sine
// times amplitude and times envelope, and loaded into the output register with
// the commit, which also takes envelope times decay; the three products share one
// 32x32 multiplier. the next tick is taken no earlier than the cycle after the load,
// while the loaded result may still wait; a stalled output holds the commit.
// synchronous reset holds in_stall high; the sine rom is constant, no clearing pass.
module decaying_sine_generator #(
  parameter int SINE_TABLE_DEPTH = dsg_pkg::DefaultSineTableDepth,
  parameter int COUNT_BITS       = dsg_pkg::DefaultCountBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsg_pkg::WordW-1:0]     sample_word,
  output logic                          sample_valid,
  output logic [dsg_pkg::FrameW-1:0]    frame_index,
  output logic                          last_sample,
  output logic [dsg_pkg::MagW-1:0]      peak_magnitude,
  output logic [dsg_pkg::FrameW-1:0]    peak_frame,
  input  logic                          cfg_write,
  input  logic [dsg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dsg_pkg::CfgDataW-1:0]  cfg_data
);
  import dsg_pkg::*;

  logic [PhaseW-1:0] phase_step;
  logic [AmpW-1:0]   amplitude;
  logic [DecayW-1:0] decay_factor;
  logic [FrameW-1:0] sample_count;
  logic              float_format;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= PHASE_STEP_RST;
      amplitude    <= AMPLITUDE_RST;
      decay_factor <= DECAY_FACTOR_RST;
      sample_count <= SAMPLE_COUNT_RST;
      float_format <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PHASE_STEP:   phase_step   <= cfg_data[PhaseW-1:0];
        CFG_AMPLITUDE:    amplitude    <= cfg_data[AmpW-1:0];
        CFG_DECAY_FACTOR: decay_factor <= cfg_data[DecayW-1:0];
        CFG_SAMPLE_COUNT: sample_count <= cfg_data[FrameW-1:0];
        CFG_FLOAT_FORMAT: float_format <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  dsg_cmd_t    cmd;
  dsg_status_t st;

  dsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  dsg_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .COUNT_BITS       (COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .restart        (restart),
    .phase_step     (phase_step),
    .amplitude      (amplitude),
    .decay_factor   (decay_factor),
    .sample_count   (sample_count),
    .float_format   (float_format),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample_word    (sample_word),
    .sample_valid   (sample_valid),
    .frame_index    (frame_index),
    .last_sample    (last_sample),
    .peak_magnitude (peak_magnitude),
    .peak_frame     (peak_frame)
  );

endmodule
